// ===== design/lud_pkg.sv =====
package lud_pkg;

  // sizing of the device set and the placement table
  localparam int MAX_DEVICES   = 4;
  localparam int TABLE_ENTRIES = 16;

  localparam int DEV_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int KEY_W     = 32;
  localparam int SIZE_W    = 40;
  localparam int OUT_DEV_W = 2;
  localparam int DUI_W     = 3;
  localparam int ACT_W     = 4;

  // configuration port
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_W        = 40;
  localparam int NUM_CAP_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICES_IN_USE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_0     = 3'd1;

  localparam logic [DUI_W-1:0]  DUI_RESET = 3'd4;
  localparam logic [SIZE_W-1:0] CAP_RESET = 40'd1073741824;

  // request kinds
  localparam logic REQ_PLACE   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // result codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MODEL = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_DUP       = 3'd3,
    ST_NO_MEM    = 3'd4,
    ST_UNKNOWN   = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  model_key;
    logic [SIZE_W-1:0] size_bytes;
  } lud_in_t;

  typedef struct packed {
    status_t              status;
    logic [OUT_DEV_W-1:0] device_index;
  } lud_out_t;

  // controller to datapath
  typedef struct packed {
    logic             load_req;
    logic             scan_clear;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             dev_clear;
    logic             dev_step;
    logic [DEV_W-1:0] dev_idx;
    logic             place_commit;
    logic             rel_commit;
  } lud_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic                 is_release;
    logic                 key_zero;
    logic                 size_zero;
    logic                 hit;
    logic                 last;
    logic [DEV_W-1:0]     act_last;
    logic                 sel_found;
    logic                 free_found;
    logic [OUT_DEV_W-1:0] sel_dev;
    logic [OUT_DEV_W-1:0] hit_dev;
  } lud_sts_t;

  // device number as it appears on the result port
  function automatic logic [OUT_DEV_W-1:0] to_out_dev(input logic [DEV_W-1:0] d);
    logic [DEV_W+OUT_DEV_W-1:0] w;
    w = {{OUT_DEV_W{1'b0}}, d};
    return w[OUT_DEV_W-1:0];
  endfunction

endpackage

// ===== design/lud_ctrl.sv =====
module lud_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output lud_pkg::lud_out_t  out_data,
  output lud_pkg::lud_cmd_t  cmd,
  input  lud_pkg::lud_sts_t  sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DEVS,
    S_DECIDE,
    S_REL,
    S_RESP
  } state_t;

  state_t                           state_r, state_nxt;
  logic [lud_pkg::CNT_W-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic [lud_pkg::DEV_W-1:0]        dev_cnt_r, dev_cnt_nxt;
  lud_pkg::status_t                 res_status_r, res_status_nxt;
  logic [lud_pkg::OUT_DEV_W-1:0]    res_dev_r, res_dev_nxt;
  logic                             out_valid_r, out_valid_nxt;
  lud_pkg::lud_out_t                out_data_r, out_data_nxt;
  logic                             out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencing of one request
  always_comb begin
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    dev_cnt_nxt    = dev_cnt_r;
    res_status_nxt = res_status_r;
    res_dev_nxt    = res_dev_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    cmd            = '0;
    out_free       = !out_valid_r || !out_stall;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.scan_clear = 1'b1;
        scan_cnt_nxt   = '0;
        res_dev_nxt    = '0;
        if (sts.is_release) begin
          state_nxt = S_SCAN;
        end else if (sts.key_zero) begin
          res_status_nxt = lud_pkg::ST_BAD_MODEL;
          state_nxt      = S_RESP;
        end else if (sts.size_zero) begin
          res_status_nxt = lud_pkg::ST_BAD_SIZE;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // one table read issued per cycle, compare lands in the next cycle
        cmd.rd_en   = (scan_cnt_r < lud_pkg::CNT_W'(lud_pkg::TABLE_ENTRIES));
        cmd.rd_addr = scan_cnt_r[lud_pkg::IDX_W-1:0];
        if (cmd.rd_en) begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if (sts.hit) begin
          if (sts.is_release) begin
            state_nxt = S_REL;
          end else begin
            res_status_nxt = lud_pkg::ST_DUP;
            state_nxt      = S_RESP;
          end
        end else if (sts.last) begin
          if (sts.is_release) begin
            res_status_nxt = lud_pkg::ST_UNKNOWN;
            state_nxt      = S_RESP;
          end else begin
            cmd.dev_clear = 1'b1;
            dev_cnt_nxt   = '0;
            state_nxt     = S_DEVS;
          end
        end
      end
      S_DEVS: begin
        cmd.dev_step = 1'b1;
        cmd.dev_idx  = dev_cnt_r;
        if (dev_cnt_r == sts.act_last) begin
          state_nxt = S_DECIDE;
        end else begin
          dev_cnt_nxt = dev_cnt_r + 1'b1;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESP;
        if (!sts.sel_found) begin
          res_status_nxt = lud_pkg::ST_NO_MEM;
        end else if (!sts.free_found) begin
          res_status_nxt = lud_pkg::ST_FULL;
        end else begin
          cmd.place_commit = 1'b1;
          res_status_nxt   = lud_pkg::ST_OK;
          res_dev_nxt      = sts.sel_dev;
        end
      end
      S_REL: begin
        cmd.rel_commit = 1'b1;
        res_status_nxt = lud_pkg::ST_OK;
        res_dev_nxt    = sts.hit_dev;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = res_status_r;
          out_data_nxt.device_index = res_dev_r;
          state_nxt                 = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_cnt_r   <= '0;
      dev_cnt_r    <= '0;
      res_status_r <= lud_pkg::ST_OK;
      res_dev_r    <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      dev_cnt_r    <= dev_cnt_nxt;
      res_status_r <= res_status_nxt;
      res_dev_r    <= res_dev_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

`ifndef SYNTH
  a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.place_commit && cmd.rel_commit))
    else $error("place and release commit in the same cycle");

  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP) && out_free |=> out_valid_r && (state_r == S_IDLE))
    else $error("result not loaded when output was free");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_req |=> (state_r == S_CHECK))
    else $error("request load did not start a check");
`endif

endmodule

// ===== design/lud_dp.sv =====
module lud_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lud_pkg::lud_in_t                  in_data,
  input  logic                              cfg_we,
  input  logic [lud_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lud_pkg::CFG_W-1:0]         cfg_wdata,
  input  lud_pkg::lud_cmd_t                 cmd,
  output lud_pkg::lud_sts_t                 sts
);

  localparam int N = lud_pkg::TABLE_ENTRIES;
  localparam int M = lud_pkg::MAX_DEVICES;

  // request and configuration
  lud_pkg::lud_in_t                 req_r;
  logic [lud_pkg::DUI_W-1:0]        dui_r;
  logic [lud_pkg::SIZE_W-1:0]       cap_r [M];
  logic [lud_pkg::SIZE_W-1:0]       used_r [M];

  // placement table
  logic [N-1:0]                     valid_r;
  logic [lud_pkg::KEY_W-1:0]        key_mem [N];
  logic [lud_pkg::DEV_W-1:0]        dev_mem [N];
  logic [lud_pkg::SIZE_W-1:0]       bytes_mem [N];

  // scan stage
  logic                             rd_act_r;
  logic                             rd_vld_r;
  logic [lud_pkg::IDX_W-1:0]        rd_addr_r;
  logic [lud_pkg::KEY_W-1:0]        rd_key_r;
  logic [lud_pkg::DEV_W-1:0]        rd_dev_r;
  logic [lud_pkg::SIZE_W-1:0]       rd_bytes_r;
  logic                             hit;
  logic [lud_pkg::IDX_W-1:0]        hit_addr_r;
  logic [lud_pkg::DEV_W-1:0]        hit_dev_r;
  logic [lud_pkg::SIZE_W-1:0]       hit_bytes_r;
  logic                             free_found_r;
  logic [lud_pkg::IDX_W-1:0]        free_addr_r;

  // device selection
  logic                             sel_found_r;
  logic [lud_pkg::DEV_W-1:0]        sel_r;
  logic [lud_pkg::SIZE_W-1:0]       best_r;
  logic [lud_pkg::DEV_W-1:0]        du_idx;
  logic [lud_pkg::SIZE_W-1:0]       used_rd;
  logic [lud_pkg::SIZE_W-1:0]       cap_rd;
  logic [lud_pkg::SIZE_W:0]         room;
  logic                             fits;
  logic                             better;
  logic [lud_pkg::ACT_W-1:0]        dui_ext;
  logic [lud_pkg::ACT_W-1:0]        act_n;
  logic [lud_pkg::DEV_W-1:0]        act_last;

  // active device count, clamped to the supported range
  always_comb begin
    dui_ext = {1'b0, dui_r};
    if (dui_r == '0) begin
      act_n = lud_pkg::ACT_W'(1);
    end else if (dui_ext > lud_pkg::ACT_W'(M)) begin
      act_n = lud_pkg::ACT_W'(M);
    end else begin
      act_n = dui_ext;
    end
    act_last = lud_pkg::DEV_W'(act_n - lud_pkg::ACT_W'(1));
  end

  // one usage read port shared by the device search and both commits
  always_comb begin
    if (cmd.dev_step) begin
      du_idx = cmd.dev_idx;
    end else if (cmd.rel_commit) begin
      du_idx = hit_dev_r;
    end else begin
      du_idx = sel_r;
    end
    used_rd = used_r[du_idx];
    cap_rd  = cap_r[cmd.dev_idx];
    room    = {1'b0, cap_rd} - {1'b0, used_rd};
    fits    = (cap_rd > used_rd) && (req_r.size_bytes <= room[lud_pkg::SIZE_W-1:0]);
    better  = !sel_found_r || (used_rd < best_r);
  end

  assign hit = rd_act_r && rd_vld_r && (rd_key_r == req_r.model_key);

  // status toward the controller
  always_comb begin
    sts.is_release = (req_r.req_type == lud_pkg::REQ_RELEASE);
    sts.key_zero   = (req_r.model_key == '0);
    sts.size_zero  = (req_r.size_bytes == '0);
    sts.hit        = hit;
    sts.last       = rd_act_r && (rd_addr_r == lud_pkg::IDX_W'(N - 1));
    sts.act_last   = act_last;
    sts.sel_found  = sel_found_r;
    sts.free_found = free_found_r;
    sts.sel_dev    = lud_pkg::to_out_dev(sel_r);
    sts.hit_dev    = lud_pkg::to_out_dev(hit_dev_r);
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dui_r <= lud_pkg::DUI_RESET;
      for (int d = 0; d < M; d++) begin
        cap_r[d] <= lud_pkg::CAP_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index == lud_pkg::CFG_DEVICES_IN_USE) begin
        dui_r <= cfg_wdata[lud_pkg::DUI_W-1:0];
      end
      for (int d = 0; d < M; d++) begin
        if ((d < lud_pkg::NUM_CAP_REGS) &&
            (cfg_index == lud_pkg::CFG_CAPACITY_0 + lud_pkg::CFG_IDX_W'(d))) begin
          cap_r[d] <= cfg_wdata[lud_pkg::SIZE_W-1:0];
        end
      end
    end
  end

  // device usage, valid bits and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < M; d++) begin
        used_r[d] <= '0;
      end
      valid_r      <= '0;
      rd_act_r     <= 1'b0;
      free_found_r <= 1'b0;
      sel_found_r  <= 1'b0;
    end else begin
      rd_act_r <= cmd.rd_en;
      if (cmd.rd_en) begin
        rd_vld_r  <= valid_r[cmd.rd_addr];
        rd_addr_r <= cmd.rd_addr;
      end
      // first free entry seen during the scan
      if (cmd.scan_clear) begin
        free_found_r <= 1'b0;
      end else if (rd_act_r && !rd_vld_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_addr_r  <= rd_addr_r;
      end
      if (hit) begin
        hit_addr_r  <= rd_addr_r;
        hit_dev_r   <= rd_dev_r;
        hit_bytes_r <= rd_bytes_r;
      end
      // least used device that fits, lowest index on a tie
      if (cmd.dev_clear) begin
        sel_found_r <= 1'b0;
      end else if (cmd.dev_step && fits && better) begin
        sel_found_r <= 1'b1;
        sel_r       <= cmd.dev_idx;
        best_r      <= used_rd;
      end
      if (cmd.place_commit) begin
        used_r[du_idx]       <= used_rd + req_r.size_bytes;
        valid_r[free_addr_r] <= 1'b1;
      end
      if (cmd.rel_commit) begin
        used_r[du_idx]      <= (used_rd >= hit_bytes_r) ? used_rd - hit_bytes_r : '0;
        valid_r[hit_addr_r] <= 1'b0;
      end
    end
  end

  // table storage with registered read
  always_ff @(posedge clk) begin
    if (cmd.place_commit) begin
      key_mem[free_addr_r]   <= req_r.model_key;
      dev_mem[free_addr_r]   <= sel_r;
      bytes_mem[free_addr_r] <= req_r.size_bytes;
    end
    if (cmd.rd_en) begin
      rd_key_r   <= key_mem[cmd.rd_addr];
      rd_dev_r   <= dev_mem[cmd.rd_addr];
      rd_bytes_r <= bytes_mem[cmd.rd_addr];
    end
  end

`ifndef SYNTH
  a_place_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place_commit |-> sel_found_r && free_found_r && !valid_r[free_addr_r])
    else $error("placement committed without device or free entry");

  a_place_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place_commit |=> valid_r[$past(free_addr_r)])
    else $error("placed entry not marked valid");

  a_rel_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rel_commit |=> !valid_r[$past(hit_addr_r)])
    else $error("released entry still valid");

  a_dev_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dev_step |-> (cmd.dev_idx <= act_last))
    else $error("device step beyond the active devices");
`endif

endmodule

// ===== design/least_used_device_placement.sv =====
// Places models on the least loaded device that has room and releases them by key.
// Each transfer on the input is a place or a release and gives exactly one result.
// One request is handled at a time, from the accepting cycle until its result is
// loaded. A place with a zero key or size is answered after the check, a release
// or a duplicate place after the key lookup, which ends at the first matching entry,
// and a place that reaches the device search after a lookup of the whole table and
// a search of the active devices. The key lookup reads one table entry per cycle
// through the table's single read port, and the device search one active device
// per cycle. A finished result sits in the output register while the next request
// is taken. Configuration writes are taken at any time and are meant for when no
// request is in flight.
module least_used_device_placement (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lud_pkg::lud_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lud_pkg::lud_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [lud_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lud_pkg::CFG_W-1:0]     cfg_wdata
);

  lud_pkg::lud_cmd_t cmd;
  lud_pkg::lud_sts_t sts;

  // sequencer
  lud_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table, device usage and configuration
  lud_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
